// ===== sv/rna_pkg.sv =====
// rna_pkg: shared types and constants for the radix number-to-ascii converter
`timescale 1ns / 1ps
`default_nettype none

package rna_pkg;

  localparam int NUM_W    = 64;
  localparam int BASE_W   = 6;
  localparam int WIDTH_W  = 7;
  localparam int CODE_W   = 7;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // divider retires two quotient bits per cycle
  localparam int DIV_STEPS = NUM_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [CODE_W-1:0] ASCII_DIGIT_OFS  = 7'd48;
  localparam logic [CODE_W-1:0] ASCII_LETTER_OFS = 7'd55;
  localparam logic [BASE_W-1:0] DECIMAL_LIMIT    = 6'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_BASE   = 2'd1,
    ST_TOO_NARROW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_COUNT,
    S_COUNT_CHK,
    S_EMIT,
    S_EMIT_OUT,
    S_ERR_BASE,
    S_ERR_NARROW
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PUSH_DIGIT,
    PUSH_BAD_BASE,
    PUSH_NARROW
  } push_kind_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_step;
    logic       cnt_inc;
    logic       emit_init;
    logic       pos_dec;
    logic       push;
    push_kind_t push_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic step_last;
    logic quot_zero;
    logic too_narrow;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/rna_in_if.sv =====
// rna_in_if: input channel carrying the number, base and field width
`timescale 1ns / 1ps
`default_nettype none

interface rna_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] number;
  logic [5:0]  base;
  logic [6:0]  width;

  modport source (output valid, output number, output base, output width, input ready);
  modport sink   (input valid, input number, input base, input width, output ready);
endinterface

`default_nettype wire

// ===== sv/rna_out_if.sv =====
// rna_out_if: result channel carrying one digit character per transfer
`timescale 1ns / 1ps
`default_nettype none

interface rna_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic [5:0] position;
  logic       last;
  logic [1:0] status;
  logic [6:0] digit_count;

  modport source (output valid, output char_code, output position, output last,
                  output status, output digit_count, input ready);
  modport sink   (input valid, input char_code, input position, input last,
                  input status, input digit_count, output ready);
endinterface

`default_nettype wire

// ===== sv/rna_datapath.sv =====
// rna_datapath: operand registers, shared radix-4 divider, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module rna_datapath #(
  parameter int MAX_WIDTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rna_pkg::dp_cmd_t          cmd,
  output      rna_pkg::dp_sts_t          sts,
  input  wire logic [rna_pkg::NUM_W-1:0]   in_number,
  input  wire logic [rna_pkg::BASE_W-1:0]  in_base,
  input  wire logic [rna_pkg::WIDTH_W-1:0] in_width,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [rna_pkg::CODE_W-1:0]   out_char_code,
  output      logic [rna_pkg::POS_W-1:0]    out_position,
  output      logic                         out_last,
  output      logic [rna_pkg::STATUS_W-1:0] out_status,
  output      logic [rna_pkg::COUNT_W-1:0]  out_digit_count
);
  import rna_pkg::*;

  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_WIDTH);

  logic [NUM_W-1:0]   num_r, dvd_r, dvd_nxt;
  logic [BASE_W-1:0]  base_r, rem_r, rem_nxt;
  logic [WIDTH_W-1:0] wid_r, wid_clamped;
  logic [STEP_W-1:0]  step_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [POS_W-1:0]   pos_r;

  logic                out_valid_r;
  logic [CODE_W-1:0]   out_code_r, code_nxt;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_last_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  // two restoring steps per cycle; remainder stays below the base
  logic [BASE_W:0] div_b, r1, r1s, r2, r2s;
  logic            q1, q2;

  always_comb begin
    div_b   = {1'b0, base_r};
    r1      = {rem_r, dvd_r[NUM_W-1]};
    q1      = (r1 >= div_b);
    r1s     = q1 ? (r1 - div_b) : r1;
    r2      = {r1s[BASE_W-1:0], dvd_r[NUM_W-2]};
    q2      = (r2 >= div_b);
    r2s     = q2 ? (r2 - div_b) : r2;
    dvd_nxt = {dvd_r[NUM_W-3:0], q1, q2};
    rem_nxt = r2s[BASE_W-1:0];
  end

  assign wid_clamped = (in_width > MAX_W) ? MAX_W : in_width;

  // digit value to ascii
  assign code_nxt = (rem_r < DECIMAL_LIMIT) ? (CODE_W'(rem_r) + ASCII_DIGIT_OFS)
                                            : (CODE_W'(rem_r) + ASCII_LETTER_OFS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= in_number;
      base_r <= in_base;
      wid_r  <= wid_clamped;
      dvd_r  <= in_number;
      cnt_r  <= '0;
    end else begin
      if (cmd.emit_init) begin
        dvd_r <= num_r;
        pos_r <= POS_W'(wid_r - WIDTH_W'(1));
      end else if (cmd.div_step) begin
        dvd_r <= dvd_nxt;
      end
      if (cmd.cnt_inc) cnt_r <= cnt_r + COUNT_W'(1);
      if (cmd.pos_dec) pos_r <= pos_r - POS_W'(1);
    end

    if (cmd.div_start || cmd.emit_init) begin
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      step_r <= step_r + STEP_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      case (cmd.push_kind)
        PUSH_DIGIT: begin
          out_code_r   <= code_nxt;
          out_pos_r    <= pos_r;
          out_last_r   <= (dvd_r == '0);
          out_status_r <= ST_OK;
          out_count_r  <= (dvd_r == '0) ? cnt_r : '0;
        end
        PUSH_BAD_BASE: begin
          out_code_r   <= '0;
          out_pos_r    <= '0;
          out_last_r   <= 1'b1;
          out_status_r <= ST_BAD_BASE;
          out_count_r  <= '0;
        end
        PUSH_NARROW: begin
          out_code_r   <= '0;
          out_pos_r    <= '0;
          out_last_r   <= 1'b1;
          out_status_r <= ST_TOO_NARROW;
          out_count_r  <= cnt_r;
        end
        default: begin
          out_code_r   <= '0;
          out_pos_r    <= '0;
          out_last_r   <= 1'b1;
          out_status_r <= ST_BAD_BASE;
          out_count_r  <= '0;
        end
      endcase
    end
  end

  assign sts.base_bad   = (base_r < BASE_MIN) || (base_r > BASE_MAX);
  assign sts.step_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign sts.quot_zero  = (dvd_r == '0);
  assign sts.too_narrow = (cnt_r > wid_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_char_code   = out_code_r;
  assign out_position    = out_pos_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;
  assign out_digit_count = out_count_r;

  // a result is only loaded into a free slot
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("result pushed over an untaken result");

  // remainder stays below the base once a division has started
  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < base_r))
    else $error("divider remainder not below base");

endmodule

`default_nettype wire

// ===== sv/rna_ctrl.sv =====
// rna_ctrl: sequencer for base check, digit count pass and digit emit pass
`timescale 1ns / 1ps
`default_nettype none

module rna_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  output      rna_pkg::dp_cmd_t cmd,
  input  wire rna_pkg::dp_sts_t sts
);
  import rna_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.push_kind = PUSH_DIGIT;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.base_bad) begin
          state_nxt = S_ERR_BASE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_COUNT_CHK;
        end
      end
      S_COUNT_CHK: begin
        if (!sts.quot_zero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_COUNT;
        end else if (sts.too_narrow) begin
          state_nxt = S_ERR_NARROW;
        end else begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_DIGIT;
          if (sts.quot_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_dec   = 1'b1;
            cmd.div_start = 1'b1;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_ERR_BASE: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_BAD_BASE;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR_NARROW: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_NARROW;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // divider commands never overlap a fresh load
  a_load_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.div_step || cmd.div_start || cmd.push))
    else $error("load issued together with divider or push command");

  // the emit pass only starts on a finished count
  a_emit_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_init |-> (sts.quot_zero && !sts.too_narrow))
    else $error("emit pass started before count pass finished");

endmodule

`default_nettype wire

// ===== sv/radix_number_to_ascii.sv =====
// radix_number_to_ascii: top level joining the sequencer and the divider datapath
// sequence: a bad base gives an error result straight from the check state; otherwise each
//   digit takes one full divider pass in the counting pass and one in the emit pass, and
//   each digit result waits in the emit-output state until the output register is free
// throughput: one item at a time, set by the shared divider (two quotient bits a cycle)
// reset: synchronous active-low rst_n clears the sequencer and the output valid flag
`timescale 1ns / 1ps
`default_nettype none

module radix_number_to_ascii #(
  parameter int MAX_WIDTH = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  rna_in_if.sink   in_chan,
  rna_out_if.source out_chan
);
  import rna_pkg::*;

  // command and status bundles between sequencer and datapath
  // a new item is taken as soon as the last result sits in the output register
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns the input handshake, steps through count and emit passes
  rna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: operands, divider, digit counter and result register
  rna_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_number       (in_chan.number),
    .in_base         (in_chan.base),
    .in_width        (in_chan.width),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_char_code   (out_chan.char_code),
    .out_position    (out_chan.position),
    .out_last        (out_chan.last),
    .out_status      (out_chan.status),
    .out_digit_count (out_chan.digit_count)
  );

  // an error transfer is always the only result of its item
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && (out_chan.status != ST_OK)) |-> out_chan.last)
    else $error("error result without last marker");

  // a good transfer carries a digit or upper-case letter
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && (out_chan.status == ST_OK)) |->
      ((out_chan.char_code >= 7'd48 && out_chan.char_code <= 7'd57) ||
       (out_chan.char_code >= 7'd65 && out_chan.char_code <= 7'd90)))
    else $error("digit character out of range");

  // last good transfer reports a non-zero digit count
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last && (out_chan.status == ST_OK))
      |-> (out_chan.digit_count != '0))
    else $error("missing digit count on last result");

  // one item in flight: no input transfer straight after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while an item is in progress");

endmodule

`default_nettype wire
